// File: rtl/bmp24_stream_writer_top_defines.svh
// ----------------------------------------------------------------------------
// bmp24 stream writer assertion macros
// Shared concurrent assertion forms for the BMP stream writer RTL.
// ----------------------------------------------------------------------------
`ifndef BMP24_STREAM_WRITER_TOP_DEFINES_SVH
`define BMP24_STREAM_WRITER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BMP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define BMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bmp24_pkg.sv
// ----------------------------------------------------------------------------
// bmp24 package
// Types, constants and the header byte table of the BMP stream writer.
// ----------------------------------------------------------------------------
package bmp24_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DIM_W      = 16;
	localparam int CNT_W      = 5;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ORDER = 2'd2;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	localparam logic ORDER_RGB = 1'b0;

	localparam logic [CNT_W-1:0] HDR_BYTES = 5'd26;
	localparam logic [CNT_W-1:0] PIX_BYTES = 5'd3;

	localparam logic [7:0] CHAR_B = 8'h42;
	localparam logic [7:0] CHAR_M = 8'h4D;

	typedef struct packed {
		logic       command;
		logic [7:0] pixel_byte0;
		logic [7:0] pixel_byte1;
		logic [7:0] pixel_byte2;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       end_of_file;
	} out_item_t;

	// effective configuration seen by the datapath
	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             chan_order;
		logic [31:0]      bmp_size;
	} cfg_t;

	// what the transaction in the input stage produces
	typedef struct packed {
		logic [CNT_W-1:0] nbytes;
		logic             frame_end;
	} job_t;

	typedef struct packed {
		logic valid;
		logic command;
		logic done;
	} ser_status_t;

	function automatic logic [7:0] hdr_byte(input logic [CNT_W-1:0] idx,
		input logic [31:0] size, input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		logic [7:0] b;
		b = 8'h00;
		case (idx)
			5'd0:  b = CHAR_B;
			5'd1:  b = CHAR_M;
			5'd2:  b = size[7:0];
			5'd3:  b = size[15:8];
			5'd4:  b = size[23:16];
			5'd5:  b = size[31:24];
			5'd10: b = 8'd26;
			5'd14: b = 8'd12;
			5'd18: b = w[7:0];
			5'd19: b = w[15:8];
			5'd20: b = h[7:0];
			5'd21: b = h[15:8];
			5'd22: b = 8'd1;
			5'd24: b = 8'd24;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/bmp24_cfg_regs.sv
// ----------------------------------------------------------------------------
// bmp24 configuration registers
// Holds frame size and channel order and precomputes the size field.
// ----------------------------------------------------------------------------
module bmp24_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bmp24_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmp24_pkg::CFG_DATA_W-1:0] cfg_data,
	output bmp24_pkg::cfg_t                  cfg
);
	import bmp24_pkg::*;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             order_q;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic [17:0]      row_bytes;
	logic [17:0]      row_bytes_q;
	logic [33:0]      prod;
	logic [31:0]      size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 16'd1;
			height_q <= 16'd1;
			order_q  <= ORDER_RGB;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:   width_q  <= cfg_data;
				REG_FRAME_HEIGHT:  height_q <= cfg_data;
				REG_CHANNEL_ORDER: order_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// zero is taken as one
	assign w_eff = (width_q == '0) ? 16'd1 : width_q;
	assign h_eff = (height_q == '0) ? 16'd1 : height_q;

	assign row_bytes = {1'b0, w_eff, 1'b0} + {2'b00, w_eff} + {16'd0, w_eff[1:0]};
	assign prod      = {16'd0, row_bytes_q} * {18'd0, h_eff};

	// two register steps; settled long before the size bytes go out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= 18'd4;
			size_q      <= 32'd30;
		end else begin
			row_bytes_q <= row_bytes;
			size_q      <= prod[31:0] + 32'd26;
		end
	end

	assign cfg.width      = w_eff;
	assign cfg.height     = h_eff;
	assign cfg.chan_order = order_q;
	assign cfg.bmp_size   = size_q;

endmodule

// File: rtl/bmp24_frame_ctrl.sv
// ----------------------------------------------------------------------------
// bmp24 frame control
// Column, row and open-frame state; sizes the run of the pending transaction.
// ----------------------------------------------------------------------------
module bmp24_frame_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bmp24_pkg::cfg_t        cfg,
	input  bmp24_pkg::ser_status_t st,
	output bmp24_pkg::job_t        job
);
	import bmp24_pkg::*;

	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	logic             open_q;
	logic [DIM_W:0]   col_next;
	logic [DIM_W:0]   row_next;
	logic             row_end;
	logic             frame_end;
	logic [1:0]       pad;

	assign col_next  = {1'b0, col_q} + 17'd1;
	assign row_next  = {1'b0, row_q} + 17'd1;
	assign row_end   = col_next >= {1'b0, cfg.width};
	assign frame_end = row_end && (row_next >= {1'b0, cfg.height});
	assign pad       = row_end ? cfg.width[1:0] : 2'd0;

	always_comb begin
		job.frame_end = frame_end;
		if (st.command == CMD_START) begin
			job.nbytes = HDR_BYTES;
		end else if (open_q) begin
			job.nbytes = PIX_BYTES + {3'd0, pad};
		end else begin
			job.nbytes = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			open_q <= 1'b0;
		end else if (st.valid && st.done) begin
			if (st.command == CMD_START) begin
				col_q  <= '0;
				row_q  <= '0;
				open_q <= 1'b1;
			end else if (open_q) begin
				if (row_end) begin
					col_q <= '0;
					if (frame_end) begin
						row_q  <= '0;
						open_q <= 1'b0;
					end else begin
						row_q <= row_next[DIM_W-1:0];
					end
				end else begin
					col_q <= col_next[DIM_W-1:0];
				end
			end
		end
	end

endmodule

// File: rtl/bmp24_byte_ser.sv
// ----------------------------------------------------------------------------
// bmp24 byte serializer
// Input stage, byte index counter and output register of the byte stream.
// ----------------------------------------------------------------------------
`include "bmp24_stream_writer_top_defines.svh"

module bmp24_byte_ser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  bmp24_pkg::in_item_t    item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output bmp24_pkg::out_item_t   result,
	input  bmp24_pkg::cfg_t        cfg,
	input  bmp24_pkg::job_t        job,
	output bmp24_pkg::ser_status_t st
);
	import bmp24_pkg::*;

	logic             valid_s1;
	in_item_t         item_s1;
	logic [CNT_W-1:0] idx_q;
	logic             out_valid_q;
	out_item_t        out_q;
	logic             accept;
	logic             fire;
	logic             last;
	logic             done;
	logic [7:0]       pix_byte;
	logic [7:0]       blue;
	logic [7:0]       red;
	out_item_t        nxt;

	assign last   = (idx_q == job.nbytes - 5'd1);
	assign fire   = valid_s1 && (job.nbytes != '0) && (!out_valid_q || result_ready);
	assign done   = valid_s1 && ((job.nbytes == '0) || (fire && last));
	assign accept = item_valid && item_ready;

	assign item_ready = !valid_s1 || done;

	assign blue = (cfg.chan_order == ORDER_RGB) ? item_s1.pixel_byte2 : item_s1.pixel_byte0;
	assign red  = (cfg.chan_order == ORDER_RGB) ? item_s1.pixel_byte0 : item_s1.pixel_byte2;

	always_comb begin
		case (idx_q)
			5'd0:    pix_byte = blue;
			5'd1:    pix_byte = item_s1.pixel_byte1;
			5'd2:    pix_byte = red;
			default: pix_byte = 8'h00;
		endcase
	end

	always_comb begin
		nxt.last_of_run = last;
		if (item_s1.command == CMD_START) begin
			nxt.out_byte    = hdr_byte(idx_q, cfg.bmp_size, cfg.width, cfg.height);
			nxt.end_of_file = 1'b0;
		end else begin
			nxt.out_byte    = pix_byte;
			nxt.end_of_file = last && job.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			idx_q    <= '0;
		end else if (done) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (fire) begin
			out_q <= nxt;
		end
	end

	// hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign st.valid   = valid_s1;
	assign st.command = item_s1.command;
	assign st.done    = done;

	`BMP_ASSERT_NOW(a_idx_in_run, clk, arst_n, fire, idx_q < job.nbytes, "byte index past run")
	`BMP_ASSERT_NOW(a_eof_is_last, clk, arst_n, out_valid_q && out_q.end_of_file,
		out_q.last_of_run, "end of file without end of run")
	`BMP_ASSERT_NEXT(a_stage_frees, clk, arst_n, done && !accept, !valid_s1,
		"input stage still busy after its run")
	`BMP_ASSERT_NEXT(a_idx_steps, clk, arst_n, fire && !done, idx_q == $past(idx_q) + 5'd1,
		"byte index did not advance")

endmodule

// File: rtl/bmp24_stream_writer_top.sv
// ----------------------------------------------------------------------------
// bmp24 stream writer top
// Turns start and pixel transactions into a 24-bit BMP byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: command 0 opens a frame and yields the 26 header bytes;
//   command 1 yields three bytes B,G,R plus row padding after the last pixel
//   of a row. A pixel with no frame open is taken and yields nothing.
//   result channel: one byte per transaction, last_of_run marks the final
//   byte of an input's run, end_of_file the final byte of the frame.
//   cfg port: write frame width, height and channel order while idle.
// Timing: an input is registered in the input stage, and the first byte of
//   its run then in the output register. The byte counter of the input
//   stage emits one byte per cycle while the output is not stalled; a run is
//   3 bytes for a plain pixel, 3 to 6 at a row end, 26 for a header. The next
//   input is taken in the cycle its predecessor's last byte is registered.
// Reset: clears the frame state, width and height to 1, channel order RGB.
// Stall: while result_ready is low the output register holds its byte and
//   the run pauses; input is taken again once the current run drains.
// ----------------------------------------------------------------------------
module bmp24_stream_writer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  bmp24_pkg::in_item_t              item,
	output logic                             result_valid,
	input  logic                             result_ready,
	output bmp24_pkg::out_item_t             result,
	input  logic                             cfg_we,
	input  logic [bmp24_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmp24_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bmp24_pkg::*;

	cfg_t        cfg;
	job_t        job;
	ser_status_t st;

	bmp24_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bmp24_frame_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.st     (st),
		.job    (job)
	);

	bmp24_byte_ser u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg          (cfg),
		.job          (job),
		.st           (st)
	);

endmodule
